// File: design/tctw_pkg.sv
`default_nettype none

package tctw_pkg;

  // Operation codes as they arrive on the input channel.
  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_BS    = 3'd1;
  localparam logic [2:0] OP_GBS   = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // Command kinds after classification by the front end.
  localparam logic [2:0] K_PUT     = 3'd0;
  localparam logic [2:0] K_NEWLINE = 3'd1;
  localparam logic [2:0] K_BS      = 3'd2;
  localparam logic [2:0] K_GBS     = 3'd3;
  localparam logic [2:0] K_CLEAR   = 3'd4;
  localparam logic [2:0] K_WRITE   = 3'd5;
  localparam logic [2:0] K_READ    = 3'd6;
  localparam logic [2:0] K_NOP     = 3'd7;

  localparam logic [7:0] BLANK_CHAR   = 8'd32;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] ATTR_RESET   = 8'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [4:0] grow;
    logic [6:0] gcol;
    logic       cell_ok;
  } cmd_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [15:0] read_cell;
    logic [10:0] cursor_offset;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } res_t;

endpackage

`default_nettype wire

// File: design/tctw_front.sv
`default_nettype none

module tctw_front
  import tctw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [2:0]                           in_operation,
  input  wire logic [7:0]                           in_char_code,
  input  wire logic [7:0]                           in_cell_attribute,
  input  wire logic [4:0]                           in_cell_row,
  input  wire logic [6:0]                           in_cell_column,
  input  wire logic [4:0]                           in_guard_row,
  input  wire logic [6:0]                           in_guard_column,
  output logic                                      cmd_valid,
  input  wire logic                                 cmd_ready,
  output cmd_t                                      cmd,
  output logic [$clog2(ROWS * COLUMNS)-1:0]         cmd_addr
);

  localparam int AW = $clog2(ROWS * COLUMNS);

  logic          fv_r, fv_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [AW-1:0] addr_r;
  logic [31:0]   addr_full;
  logic          in_acc;

  assign in_tready = !fv_r || cmd_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign cmd_valid = fv_r;
  assign cmd       = cmd_r;
  assign cmd_addr  = addr_r;

  // Linear cell address for direct writes and reads, computed once here.
  assign addr_full = 32'(in_cell_row) * COLUMNS + 32'(in_cell_column);

  always_comb begin
    cmd_nxt.ch      = in_char_code;
    cmd_nxt.attr    = in_cell_attribute;
    cmd_nxt.grow    = in_guard_row;
    cmd_nxt.gcol    = in_guard_column;
    cmd_nxt.cell_ok = (32'(in_cell_row) < ROWS) && (32'(in_cell_column) < COLUMNS);
    unique case (in_operation)
      OP_PUT:   cmd_nxt.kind = (in_char_code == NEWLINE_CHAR) ? K_NEWLINE : K_PUT;
      OP_BS:    cmd_nxt.kind = K_BS;
      OP_GBS:   cmd_nxt.kind = K_GBS;
      OP_CLEAR: cmd_nxt.kind = K_CLEAR;
      OP_WRITE: cmd_nxt.kind = K_WRITE;
      OP_READ:  cmd_nxt.kind = K_READ;
      default:  cmd_nxt.kind = K_NOP;
    endcase
  end

  always_comb begin
    fv_nxt = fv_r;
    if (in_acc) begin
      fv_nxt = 1'b1;
    end else if (cmd_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= cmd_nxt;
      addr_r <= addr_full[AW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: design/tctw_queue.sv
`default_nettype none

module tctw_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != NW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: design/tctw_back.sv
`default_nettype none

module tctw_back
  import tctw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [7:0]                   text_attr,
  input  wire logic                         cmd_valid,
  output logic                              cmd_ready,
  input  wire cmd_t                         cmd,
  input  wire logic [$clog2(ROWS * COLUMNS)-1:0] cmd_addr,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output res_t                              res
);

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int SCROLL_N = CELLS - COLUMNS;
  localparam int LAST_OFF = (ROWS - 1) * COLUMNS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_FILL   = 2'd3;

  logic [15:0]   cell_mem [CELLS];
  logic [15:0]   rdata_r;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          res_valid_r, res_valid_nxt;
  res_t          res_r, res_nxt;

  logic          we, re, load, take;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, blank, read_val;

  logic [31:0]   r32, c32, gr32, gc32;
  logic [31:0]   row_ext, col_ext, off_ext;
  logic          gbs_block, gbs_left, gbs_up;

  assign blank     = {text_attr, BLANK_CHAR};
  assign take      = (state_r == S_IDLE) && cmd_valid && (!res_valid_r || res_ready);
  assign cmd_ready = take;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign r32  = 32'(row_r);
  assign c32  = 32'(col_r);
  assign gr32 = 32'(cmd.grow);
  assign gc32 = 32'(cmd.gcol);

  // The guard stops the cursor at the start of editable input.
  assign gbs_block = (r32 < gr32) || ((r32 == gr32) && (c32 <= gc32));
  assign gbs_left  = !gbs_block && (c32 != 0);
  assign gbs_up    = !gbs_block && (c32 == 0) && (r32 != 0) && ((r32 - 32'd1) >= gr32);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    off_nxt       = off_r;
    rd_ok_nxt     = rd_ok_r;
    res_valid_nxt = res_valid_r && !res_ready;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = blank;
    re            = 1'b0;
    raddr         = cmd_addr;
    load          = 1'b0;
    read_val      = 16'd0;

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (cmd.kind)
            K_PUT: begin
              we    = 1'b1;
              waddr = off_r;
              wdata = {text_attr, cmd.ch};
              load  = 1'b1;
              if (col_r == CW'(COLUMNS - 1)) begin
                col_nxt = '0;
                if (row_r == RW'(ROWS - 1)) begin
                  row_nxt = '0;
                  off_nxt = '0;
                end else begin
                  row_nxt = row_r + RW'(1);
                  off_nxt = off_r + AW'(1);
                end
              end else begin
                col_nxt = col_r + CW'(1);
                off_nxt = off_r + AW'(1);
              end
            end
            K_NEWLINE: begin
              col_nxt = '0;
              if (row_r == RW'(ROWS - 1)) begin
                off_nxt   = AW'(LAST_OFF);
                idx_nxt   = '0;
                state_nxt = S_SCROLL;
              end else begin
                row_nxt = row_r + RW'(1);
                off_nxt = off_r - AW'(col_r) + AW'(COLUMNS);
                load    = 1'b1;
              end
            end
            K_BS: begin
              load = 1'b1;
              if (col_r != '0) begin
                col_nxt = col_r - CW'(1);
                off_nxt = off_r - AW'(1);
                we      = 1'b1;
                waddr   = off_r - AW'(1);
              end
            end
            K_GBS: begin
              load = 1'b1;
              if (gbs_left) begin
                col_nxt = col_r - CW'(1);
                off_nxt = off_r - AW'(1);
                we      = 1'b1;
                waddr   = off_r - AW'(1);
              end else if (gbs_up) begin
                // The last cell of the previous row sits just below the current offset.
                row_nxt = row_r - RW'(1);
                col_nxt = CW'(COLUMNS - 1);
                off_nxt = off_r - AW'(1);
                we      = 1'b1;
                waddr   = off_r - AW'(1);
              end
            end
            K_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              off_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = S_FILL;
            end
            K_WRITE: begin
              load  = 1'b1;
              we    = cmd.cell_ok;
              waddr = cmd_addr;
              wdata = {cmd.attr, cmd.ch};
            end
            K_READ: begin
              re        = 1'b1;
              raddr     = cmd_addr;
              rd_ok_nxt = cmd.cell_ok;
              state_nxt = S_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load      = 1'b1;
        read_val  = rd_ok_r ? rdata_r : 16'd0;
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        // Reads run one row ahead of writes; each word is written in the cycle after its read.
        if (idx_r != AW'(SCROLL_N)) begin
          re      = 1'b1;
          raddr   = idx_r + AW'(COLUMNS);
          idx_nxt = idx_r + AW'(1);
        end else begin
          state_nxt = S_FILL;
        end
        if (idx_r != '0) begin
          we    = 1'b1;
          waddr = idx_r - AW'(1);
          wdata = rdata_r;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = idx_r;
        wdata = blank;
        if (idx_r == AW'(CELLS - 1)) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      res_valid_nxt = 1'b1;
    end
  end

  assign row_ext = 32'(row_nxt);
  assign col_ext = 32'(col_nxt);
  assign off_ext = 32'(off_nxt);

  always_comb begin
    res_nxt               = res_r;
    if (load) begin
      res_nxt.cursor_row    = row_ext[4:0];
      res_nxt.cursor_column = col_ext[6:0];
      res_nxt.cursor_offset = off_ext[10:0];
      res_nxt.read_cell     = read_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      off_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      off_r       <= off_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    rd_ok_r <= rd_ok_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= cell_mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/text_cell_terminal_writer_core.sv
// Character-cell text terminal with a ROWS x COLUMNS store of 16-bit cells.
// Input channel in_*: one item is one operation (put character, backspace,
// guarded backspace, clear, direct cell write, cell read). Output channel out_*:
// exactly one result item per input item, in order, carrying the cursor, its
// linear offset and, for a cell read, the cell word.
// Configuration channel cfg_*: writes the current attribute byte; it is always
// ready and is meant to be written while no item is in flight.
// Each item passes the front stage register, the queue and the result register;
// a cell read also passes the store's read register. A newline on the bottom
// row first scrolls the store up one row and blanks the last row; a clear first
// blanks the whole store. The scroll reads one word and writes one word per
// cycle, the clear writes one word per cycle. Otherwise one simple item per
// cycle passes while the receiver keeps up.
// A front stage and a two-entry queue keep accepting items while the back end
// is busy or the receiver stalls; once they are full in_tready drops. A result
// waits in the output register until out_tready.
// Reset clears the cursor to row 0, column 0 and the attribute to 5. The cell
// store is undefined until the first clear or write.
`default_nettype none

module text_cell_terminal_writer_core
  import tctw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // operation[2:0]
  input  wire logic [2:0]  in_tuser,
  // char_code[7:0], cell_attribute[15:8], cell_row[20:16], cell_column[27:21],
  // guard_row[32:28], guard_column[39:33]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cursor_row[4:0], cursor_column[11:5], cursor_offset[22:12], read_cell[38:23],
  // zero[39]
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int AW    = $clog2(ROWS * COLUMNS);
  localparam int CMD_W = $bits(cmd_t);
  localparam int QW    = CMD_W + AW;

  logic [7:0]    attr_r;
  logic [2:0]    inflight_r, inflight_nxt;

  logic          f_valid, f_ready;
  cmd_t          f_cmd;
  logic [AW-1:0] f_addr;
  logic          q_valid, q_ready;
  logic [QW-1:0] q_data;
  cmd_t          q_cmd;
  logic [AW-1:0] q_addr;
  res_t          out_res;
  logic          in_acc, out_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign q_cmd     = cmd_t'(q_data[CMD_W-1:0]);
  assign q_addr    = q_data[QW-1:CMD_W];
  assign out_tdata = {1'b0, out_res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_data;
    end
  end

  tctw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_operation     (in_tuser),
    .in_char_code     (in_tdata[7:0]),
    .in_cell_attribute(in_tdata[15:8]),
    .in_cell_row      (in_tdata[20:16]),
    .in_cell_column   (in_tdata[27:21]),
    .in_guard_row     (in_tdata[32:28]),
    .in_guard_column  (in_tdata[39:33]),
    .cmd_valid        (f_valid),
    .cmd_ready        (f_ready),
    .cmd              (f_cmd),
    .cmd_addr         (f_addr)
  );

  tctw_queue #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_addr, f_cmd}),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  tctw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .text_attr(attr_r),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd      (q_cmd),
    .cmd_addr (q_addr),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (out_res)
  );

  // Items between acceptance and delivery: front stage, queue, back end, output.
  assign inflight_nxt = inflight_r + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd5)
    else $error("more items in flight than the pipeline can hold");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != 3'd0)
    else $error("result presented with no item in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_res.cursor_row) < ROWS) &&
                   (32'(out_res.cursor_column) < COLUMNS))
    else $error("cursor outside the screen");

  a_offset_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (ROWS <= 32) && (COLUMNS <= 128)) |->
      (out_res.cursor_offset ==
       11'(32'(out_res.cursor_row) * COLUMNS + 32'(out_res.cursor_column))))
    else $error("cursor offset does not match row and column");

endmodule

`default_nettype wire
